@@ src/h264br_pkg.sv @@
// Shared types, codes and coded-block-pattern tables of the bit reader.
`timescale 1ns / 1ps

package h264br_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 4096;
  localparam int MAX_BITS = 32;
  localparam logic [1:0] CHROMA_RESET = 2'd1;
  localparam logic [1:0] PRED_INTRA = 2'd0;
  localparam logic [1:0] PRED_INTER = 2'd1;
  localparam logic [31:0] WIDE_TABLE_SIZE = 32'd48;
  localparam logic [31:0] NARROW_TABLE_SIZE = 32'd16;

  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_READ   = 3'd1,
    ACT_PEEK   = 3'd2,
    ACT_SKIP   = 3'd3,
    ACT_UE     = 3'd4,
    ACT_SE     = 3'd5,
    ACT_ME     = 3'd6,
    ACT_CLEAR  = 3'd7
  } action_t;

  // Request to the code mapper: the ue accumulator holds 2^zeros | suffix.
  typedef struct packed {
    logic        valid;
    action_t     kind;
    logic [1:0]  pred_class;
    logic        wide;
    logic [32:0] acc;
  } map_req_t;

  typedef struct packed {
    logic        valid;
    logic [32:0] value;
    logic        out_of_table;
  } map_rsp_t;

  localparam logic [5:0] CBP_INTRA_48 [48] = '{
    6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
    6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
    6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
    6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
    6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
    6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
  };

  localparam logic [5:0] CBP_INTER_48 [48] = '{
    6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
    6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
    6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
    6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
    6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
    6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41
  };

  localparam logic [5:0] CBP_INTRA_16 [16] = '{
    6'd15, 6'd0, 6'd7, 6'd11, 6'd13, 6'd14, 6'd3, 6'd5,
    6'd10, 6'd12, 6'd1, 6'd2, 6'd4, 6'd8, 6'd6, 6'd9
  };

  localparam logic [5:0] CBP_INTER_16 [16] = '{
    6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd3, 6'd5, 6'd10,
    6'd12, 6'd15, 6'd7, 6'd11, 6'd13, 6'd14, 6'd6, 6'd9
  };

  // The caller guarantees that idx lies inside the selected table.
  function automatic logic [5:0] cbp_lookup(logic inter, logic wide, logic [5:0] idx);
    logic [5:0] entry;
    if (wide) begin
      entry = inter ? CBP_INTER_48[idx] : CBP_INTRA_48[idx];
    end else begin
      entry = inter ? CBP_INTER_16[idx[3:0]] : CBP_INTRA_16[idx[3:0]];
    end
    return entry;
  endfunction

endpackage

@@ src/h264br_byte_store.sv @@
// Byte store of the stream: one write port and one registered read port.
`timescale 1ns / 1ps

module h264br_byte_store
  import h264br_pkg::*;
#(
  parameter int DEPTH = BUFFER_BYTES_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/h264br_code_map.sv @@
// Two-stage mapper from the ue accumulator to ue, se and me values.
`timescale 1ns / 1ps

module h264br_code_map
  import h264br_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  map_req_t req,
  output map_rsp_t rsp
);

  logic        s1_valid;
  action_t     s1_kind;
  logic [1:0]  s1_class;
  logic        s1_wide;
  logic [31:0] s1_code;

  logic [32:0] code_ext;
  logic [32:0] map_value;
  logic        map_oot;
  logic [31:0] table_size;

  // Stage one: code number = accumulator - 1, modulo 2^32.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
    end
    s1_kind  <= req.kind;
    s1_class <= req.pred_class;
    s1_wide  <= req.wide;
    s1_code  <= 32'(req.acc - 33'd1);
  end

  always_comb begin
    code_ext   = {1'b0, s1_code};
    table_size = s1_wide ? WIDE_TABLE_SIZE : NARROW_TABLE_SIZE;
    map_value  = code_ext;
    map_oot    = 1'b0;
    case (s1_kind)
      ACT_SE: begin
        if (s1_code[0]) begin
          map_value = (code_ext + 33'd1) >> 1;
        end else begin
          map_value = 33'd0 - {2'b00, s1_code[31:1]};
        end
      end
      ACT_ME: begin
        map_value = '0;
        if (s1_class == PRED_INTRA || s1_class == PRED_INTER) begin
          if (s1_code >= table_size) begin
            map_oot = 1'b1;
          end else begin
            map_value = {27'd0, cbp_lookup(s1_class == PRED_INTER, s1_wide, s1_code[5:0])};
          end
        end
      end
      default: begin
        map_value = code_ext;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else begin
      rsp.valid <= s1_valid;
    end
    rsp.value        <= map_value;
    rsp.out_of_table <= map_oot;
  end

endmodule

@@ src/h264_bit_reader_exp_golomb.sv @@
// Top level: MSB-first bit reader with Exp-Golomb ue, se and me decoding.
// Append and clear complete from the idle state without raising busy and may follow one another back to back.
// Read, peek and skip of n bits fetch a new byte from the store at each byte boundary.
// ue, se and me also fetch a new byte at each byte boundary and then wait for the code mapper.
// The done strobe is high in the cycle after the final busy cycle; the receiver cannot stall it.
// Synchronous reset empties the stream and sets chroma_array_type to 1; the store is kept.
`timescale 1ns / 1ps

module h264_bit_reader_exp_golomb
  import h264br_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration: chroma array type, written whenever cfg_we is high.
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  // Command side: an item is taken when start is high and busy is low.
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         action,
  input  logic [7:0]         data_byte,
  input  logic [5:0]         bit_count,
  input  logic [1:0]         pred_mode_class,
  // Result side: valid for the single cycle in which done is high.
  output logic               done,
  output logic signed [32:0] value,
  output logic               at_end,
  output logic               code_out_of_table,
  output logic               byte_aligned
);

  // The position saturates at BUFFER_BYTES, so it needs one value more than an address.
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam logic [PW-1:0] POS_LIMIT = PW'(BUFFER_BYTES);
  localparam logic [5:0] COUNT_LIMIT = 6'(MAX_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_BITS,
    S_MAP
  } state_t;

  state_t state;

  // Architectural reader state.
  logic [PW-1:0] pos;
  logic [PW-1:0] len;
  logic [3:0]    bits;
  logic [1:0]    chroma;

  // Working copy of the read pointer while an item is in progress, so that
  // a peek can simply drop it at the end.
  logic [PW-1:0] wpos;
  logic [3:0]    wbits;
  logic [32:0]   acc;
  logic [5:0]    cnt;
  logic          prefix;
  action_t       act;
  logic [1:0]    pclass;

  logic [7:0]    rd_data;
  logic          wr_en;
  logic          take;
  action_t       in_action;
  logic [5:0]    in_count;
  logic [PW-1:0] len_next;
  logic [2:0]    bit_idx;
  logic          cur_bit;
  logic          crossing;
  logic [PW-1:0] wpos_step;
  logic [3:0]    wbits_step;
  logic          ue_kind;
  logic          finishing;
  logic          prefix_goes_on;
  map_req_t      map_req;
  map_rsp_t      map_rsp;

  assign busy      = (state != S_IDLE);
  assign take      = start && !busy;
  assign in_action = action_t'(action);
  assign in_count  = (bit_count > COUNT_LIMIT) ? COUNT_LIMIT : bit_count;
  assign len_next  = (len < POS_LIMIT) ? len + 1'b1 : len;
  assign wr_en     = take && (in_action == ACT_APPEND) && (len < POS_LIMIT);

  // Outside the byte fetches, one bit per cycle is taken from the byte that the store last returned.
  // Bits at or beyond the stream length read as zero.
  assign bit_idx    = 3'(wbits - 4'd1);
  assign cur_bit    = (wpos < len) ? rd_data[bit_idx] : 1'b0;
  assign crossing   = (wbits == 4'd1);
  assign wpos_step  = (crossing && (wpos < POS_LIMIT)) ? wpos + 1'b1 : wpos;
  assign wbits_step = crossing ? 4'd8 : wbits - 4'd1;

  assign ue_kind   = (act == ACT_UE) || (act == ACT_SE) || (act == ACT_ME);
  assign finishing = (state == S_BITS) && !prefix && (cnt == 6'd0);

  // The prefix grows while a zero comes in, fewer than 32 zeros have been
  // counted and the stream has not run out.
  assign prefix_goes_on = !cur_bit && (cnt < COUNT_LIMIT) && (wpos_step < len);

  always_comb begin
    map_req.valid      = finishing && ue_kind;
    map_req.kind       = act;
    map_req.pred_class = pclass;
    map_req.wide       = (chroma == 2'd1) || (chroma == 2'd2);
    map_req.acc        = acc;
  end

  h264br_byte_store #(
    .DEPTH (BUFFER_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (len[AW-1:0]),
    .wr_data (data_byte),
    .rd_en   (state == S_FETCH),
    .rd_addr (wpos[AW-1:0]),
    .rd_data (rd_data)
  );

  h264br_code_map u_map (
    .clk (clk),
    .rst (rst),
    .req (map_req),
    .rsp (map_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pos    <= '0;
      len    <= '0;
      bits   <= 4'd8;
      chroma <= CHROMA_RESET;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        chroma <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            act    <= in_action;
            pclass <= pred_mode_class;
            wpos   <= pos;
            wbits  <= bits;
            case (in_action)
              ACT_APPEND: begin
                len               <= len_next;
                value             <= '0;
                code_out_of_table <= 1'b0;
                at_end            <= (pos >= len_next);
                byte_aligned      <= (bits == 4'd8);
                done              <= 1'b1;
              end
              ACT_CLEAR: begin
                pos               <= '0;
                len               <= '0;
                bits              <= 4'd8;
                value             <= '0;
                code_out_of_table <= 1'b0;
                at_end            <= 1'b1;
                byte_aligned      <= 1'b1;
                done              <= 1'b1;
              end
              ACT_UE, ACT_SE, ACT_ME: begin
                // The accumulator starts at one, so after the suffix it holds
                // 2^zeros + suffix, the code number plus one.
                acc    <= 33'd1;
                cnt    <= '0;
                prefix <= 1'b1;
                state  <= S_FETCH;
              end
              default: begin
                acc    <= '0;
                cnt    <= in_count;
                prefix <= 1'b0;
                state  <= S_FETCH;
              end
            endcase
          end
        end
        S_FETCH: begin
          state <= S_BITS;
        end
        S_BITS: begin
          if (prefix) begin
            wpos  <= wpos_step;
            wbits <= wbits_step;
            if (prefix_goes_on) begin
              cnt <= cnt + 6'd1;
            end else begin
              prefix <= 1'b0;
            end
            state <= crossing ? S_FETCH : S_BITS;
          end else if (cnt != 6'd0) begin
            wpos  <= wpos_step;
            wbits <= wbits_step;
            acc   <= {acc[31:0], cur_bit};
            cnt   <= cnt - 6'd1;
            state <= crossing ? S_FETCH : S_BITS;
          end else if (ue_kind) begin
            pos   <= wpos;
            bits  <= wbits;
            state <= S_MAP;
          end else begin
            // Read, peek or skip is complete; a peek leaves the pointer alone.
            if (act != ACT_PEEK) begin
              pos          <= wpos;
              bits         <= wbits;
              at_end       <= (wpos >= len);
              byte_aligned <= (wbits == 4'd8);
            end else begin
              at_end       <= (pos >= len);
              byte_aligned <= (bits == 4'd8);
            end
            value             <= (act == ACT_SKIP) ? '0 : acc;
            code_out_of_table <= 1'b0;
            done              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_MAP: begin
          if (map_rsp.valid) begin
            value             <= map_rsp.value;
            code_out_of_table <= map_rsp.out_of_table;
            at_end            <= (pos >= len);
            byte_aligned      <= (bits == 4'd8);
            done              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
